// ----- sv/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16LE to UTF-8 converter.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int MaxCodePoints = 256;
  localparam int CpCountW      = $clog2(MaxCodePoints + 1);

  localparam logic [15:0] CapReset = 16'd256;

  localparam logic [5:0] HiSurPrefix = 6'b110110;
  localparam logic [5:0] LoSurPrefix = 6'b110111;
  localparam logic [4:0] SurPrefix   = 5'b11011;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            status;
    logic            eos;
    logic [15:0]     base;
  } u16u8_bundle_t;

endpackage

// ----- sv/u16u8_if.sv -----
// ----------------------------------------------------------------------------
// u16u8 channel interfaces
// Input word, output word and capacity write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface u16u8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, in_byte, final_byte, input ready);
  modport sink   (input valid, in_byte, final_byte, output ready);
endinterface

interface u16u8_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        end_of_string;
  logic        bad_input;
  logic [15:0] total_length;

  modport source (output valid, out_byte, byte_valid, end_of_string, bad_input,
                  total_length, input ready);
  modport sink   (input valid, out_byte, byte_valid, end_of_string, bad_input,
                  total_length, output ready);
endinterface

interface u16u8_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_capacity;

  modport source (output valid, out_capacity, input ready);
  modport sink   (input valid, out_capacity, output ready);
endinterface

// ----- sv/u16u8_decode.sv -----
// ----------------------------------------------------------------------------
// u16u8_decode
// Input register, string state and single-pass decode of one input word into
// a bundle of up to four results.
// ----------------------------------------------------------------------------
module u16u8_decode (
  input  logic                     clk,
  input  logic                     rst,
  u16u8_in_if.sink                 upstream,
  u16u8_cfg_if.sink                cfg,
  output u16u8_pkg::u16u8_bundle_t bnd,
  output logic                     bnd_valid,
  input  logic                     bnd_ready
);
  import u16u8_pkg::*;

  logic                iv;
  logic [7:0]          ib;
  logic                ifin;
  logic [15:0]         out_capacity;

  logic                odd_phase, odd_phase_next;
  logic [7:0]          low_byte_hold, low_byte_hold_next;
  logic                hs_pending, hs_pending_next;
  logic [9:0]          hs_bits, hs_bits_next;
  logic [15:0]         bytes_out_count, bytes_out_count_next;
  logic [CpCountW-1:0] cp_count, cp_count_next;
  logic                error_latched, error_latched_next;

  logic                take;
  logic [15:0]         unit;
  logic [20:0]         cp;
  logic [2:0]          n;
  logic [3:0][7:0]     enc;
  logic                emit_cp;
  logic                do_fail;
  logic                clear;
  logic                cap_fail;

  assign take           = iv && bnd_ready;
  assign upstream.ready = !iv || take;
  assign cfg.ready      = 1'b1;
  assign bnd_valid      = iv;
  assign unit           = {ib, low_byte_hold};

  always_comb begin
    enc = '0;
    n   = 3'd1;
    if (cp <= 21'h7f) begin
      enc[0] = cp[7:0];
      n      = 3'd1;
    end else if (cp <= 21'h7ff) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      n      = 3'd2;
    end else if (cp <= 21'hffff) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      n      = 3'd3;
    end else begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      n      = 3'd4;
    end
  end

  assign cap_fail = ({1'b0, bytes_out_count} + 17'(n) + 17'd1) >= {1'b0, out_capacity};

  always_comb begin
    odd_phase_next       = odd_phase;
    low_byte_hold_next   = low_byte_hold;
    hs_pending_next      = hs_pending;
    hs_bits_next         = hs_bits;
    bytes_out_count_next = bytes_out_count;
    cp_count_next        = cp_count;
    error_latched_next   = error_latched;
    cp                   = 21'(unit);
    emit_cp              = 1'b0;
    do_fail              = 1'b0;
    clear                = 1'b0;
    bnd                  = '0;
    bnd.base             = bytes_out_count;

    if (error_latched) begin
      if (ifin) begin
        bnd.count  = 3'd1;
        bnd.status = 1'b1;
        bnd.eos    = 1'b1;
        clear      = 1'b1;
      end
    end else if (!odd_phase) begin
      if (ifin) begin
        do_fail = 1'b1;
      end else begin
        low_byte_hold_next = ib;
        odd_phase_next     = 1'b1;
      end
    end else begin
      odd_phase_next = 1'b0;
      if (hs_pending) begin
        if (unit[15:10] == LoSurPrefix) begin
          hs_pending_next = 1'b0;
          cp              = 21'h10000 + 21'({hs_bits, unit[9:0]});
          emit_cp         = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end else if (unit[15:11] != SurPrefix) begin
        emit_cp = 1'b1;
      end else if (unit[15:10] == HiSurPrefix) begin
        if (ifin) begin
          do_fail = 1'b1;
        end else begin
          hs_pending_next = 1'b1;
          hs_bits_next    = unit[9:0];
        end
      end else begin
        do_fail = 1'b1;
      end
    end

    if (emit_cp) begin
      if (cp_count >= CpCountW'(MaxCodePoints) || cap_fail) begin
        do_fail = 1'b1;
      end else begin
        cp_count_next        = cp_count + 1'b1;
        bytes_out_count_next = bytes_out_count + 16'(n);
        bnd.bytes            = enc;
        bnd.count            = n;
        bnd.eos              = ifin;
        clear                = ifin;
      end
    end

    if (do_fail) begin
      error_latched_next = 1'b1;
      bnd.bytes          = '0;
      bnd.count          = 3'd1;
      bnd.status         = 1'b1;
      bnd.eos            = ifin;
      clear              = ifin;
    end

    if (clear) begin
      odd_phase_next       = 1'b0;
      low_byte_hold_next   = '0;
      hs_pending_next      = 1'b0;
      hs_bits_next         = '0;
      bytes_out_count_next = '0;
      cp_count_next        = '0;
      error_latched_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv              <= 1'b0;
      out_capacity    <= CapReset;
      odd_phase       <= 1'b0;
      low_byte_hold   <= '0;
      hs_pending      <= 1'b0;
      hs_bits         <= '0;
      bytes_out_count <= '0;
      cp_count        <= '0;
      error_latched   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        out_capacity <= cfg.out_capacity;
      end
      if (upstream.valid && upstream.ready) begin
        iv <= 1'b1;
      end else if (take) begin
        iv <= 1'b0;
      end
      if (take) begin
        odd_phase       <= odd_phase_next;
        low_byte_hold   <= low_byte_hold_next;
        hs_pending      <= hs_pending_next;
        hs_bits         <= hs_bits_next;
        bytes_out_count <= bytes_out_count_next;
        cp_count        <= cp_count_next;
        error_latched   <= error_latched_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upstream.valid && upstream.ready) begin
      ib   <= upstream.in_byte;
      ifin <= upstream.final_byte;
    end
  end

endmodule

// ----- sv/u16u8_emit.sv -----
// ----------------------------------------------------------------------------
// u16u8_emit
// Bundle register and output register: sends the bundle's results one word
// per cycle while downstream is ready.
// ----------------------------------------------------------------------------
module u16u8_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  u16u8_pkg::u16u8_bundle_t bnd,
  input  logic                     bnd_valid,
  output logic                     bnd_ready,
  u16u8_out_if.source              downstream
);
  import u16u8_pkg::*;

  u16u8_bundle_t held;
  logic [2:0]    rem;
  logic [1:0]    idx;
  logic          out_valid;
  logic [7:0]    out_byte;
  logic          byte_valid;
  logic          end_of_string;
  logic          bad_input;
  logic [15:0]   total_length;
  logic          out_load;

  assign out_load  = !out_valid || downstream.ready;
  assign bnd_ready = (rem == 3'd0) || (rem == 3'd1 && out_load);

  assign downstream.valid         = out_valid;
  assign downstream.out_byte      = out_byte;
  assign downstream.byte_valid    = byte_valid;
  assign downstream.end_of_string = end_of_string;
  assign downstream.bad_input     = bad_input;
  assign downstream.total_length  = total_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= (rem != 3'd0);
      end
      if (bnd_valid && bnd_ready) begin
        rem <= bnd.count;
        idx <= '0;
      end else if (out_load && rem != 3'd0) begin
        rem <= rem - 3'd1;
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_valid && bnd_ready) begin
      held <= bnd;
    end
    if (out_load && rem != 3'd0) begin
      out_byte      <= held.status ? 8'd0 : held.bytes[idx];
      byte_valid    <= !held.status;
      bad_input     <= held.status;
      end_of_string <= held.eos && (rem == 3'd1);
      total_length  <= held.status ? held.base : 16'(held.base + 16'(idx) + 16'd1);
    end
  end

endmodule

// ----- sv/utf16le_to_utf8_converter_top.sv -----
// An accepted input word passes the input, bundle and output registers.
// Throughput: one input word per cycle and one output word per cycle while
// downstream is ready; a word completing a multi-byte code point holds the
// input until its bytes are sent. The single output register sets the rate.
// Reset: synchronous, active high; clears string state, capacity goes to 256.
// ----------------------------------------------------------------------------
// utf16le_to_utf8_converter_top
// UTF-16LE byte stream in, UTF-8 byte stream out, with error and length status.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_converter_top (
  input  logic        clk,
  input  logic        rst,
  u16u8_in_if.sink    upstream,
  u16u8_out_if.source downstream,
  u16u8_cfg_if.sink   cfg
);
  import u16u8_pkg::*;

  u16u8_bundle_t bnd;
  logic          bnd_valid;
  logic          bnd_ready;

  u16u8_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .upstream  (upstream),
    .cfg       (cfg),
    .bnd       (bnd),
    .bnd_valid (bnd_valid),
    .bnd_ready (bnd_ready)
  );

  u16u8_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .bnd        (bnd),
    .bnd_valid  (bnd_valid),
    .bnd_ready  (bnd_ready),
    .downstream (downstream)
  );

endmodule

// ----- sv/u16u8_checker.sv -----
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks on the converter's output channel.
// ----------------------------------------------------------------------------
module u16u8_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic        end_of_string,
  input logic        bad_input,
  input logic [15:0] total_length
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(byte_valid) && $stable(end_of_string) && $stable(bad_input) &&
      $stable(total_length))
    else $error("output word changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> bad_input && out_byte == 8'd0)
    else $error("status word without error flag or with data");

  a_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> !bad_input && total_length != 16'd0)
    else $error("data word with error flag or zero length");

  a_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && byte_valid && out_byte[7:6] == 2'b11 |-> !end_of_string)
    else $error("string ended on a lead byte");

endmodule

bind utf16le_to_utf8_converter_top u16u8_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (downstream.valid),
  .out_ready     (downstream.ready),
  .out_byte      (downstream.out_byte),
  .byte_valid    (downstream.byte_valid),
  .end_of_string (downstream.end_of_string),
  .bad_input     (downstream.bad_input),
  .total_length  (downstream.total_length)
);
